>>> design/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared constants, control types and state encoding for the median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int CFG_W          = 7;
    localparam int SAMPLE_W       = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_DEL
    } t_swm_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic flush;
        logic remove;
    } t_cell_ctrl;

endpackage

>>> design/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median cell
// One slot of the sorted window: value, age and valid flag, shifting right
// on insertion and left on removal of the oldest entry.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swm_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [IW-1:0]                       i_oldest_age,
    input  logic [IW-1:0]                       i_del_pos,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic [IW-1:0]                       i_left_age,
    input  logic                                i_left_valid,
    input  logic                                i_left_take,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_right_val,
    input  logic [IW-1:0]                       i_right_age,
    input  logic                                i_right_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_val,
    output logic [IW-1:0]                       o_age,
    output logic                                o_valid,
    output logic                                o_take,
    output logic                                o_match
);

    logic signed [swm_pkg::SAMPLE_W-1:0] r_val;
    logic [IW-1:0]                       r_age;
    logic                                r_valid;
    logic                                w_valid_eff;
    logic                                w_left_valid_eff;
    logic                                w_shift;

    assign w_valid_eff      = r_valid & ~i_ctrl.flush;
    assign w_left_valid_eff = i_left_valid & ~i_ctrl.flush;
    assign o_take           = ~w_valid_eff | (r_val > i_sample);
    assign o_match          = r_valid & (r_age == i_oldest_age);
    assign w_shift          = r_valid & (IW'(INDEX) >= i_del_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert) begin
            if (i_left_take) begin
                r_valid <= w_left_valid_eff;
            end else if (o_take) begin
                r_valid <= 1'b1;
            end else begin
                r_valid <= w_valid_eff;
            end
        end else if (i_ctrl.remove && w_shift) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (i_left_take) begin
                r_val <= i_left_val;
                r_age <= i_left_age + 1'b1;
            end else if (o_take) begin
                r_val <= i_sample;
                r_age <= '0;
            end else begin
                r_age <= r_age + 1'b1;
            end
        end else if (i_ctrl.remove && w_shift) begin
            r_val <= i_right_val;
            r_age <= i_right_age;
        end
    end

    assign o_val   = r_val;
    assign o_age   = r_age;
    assign o_valid = r_valid;

endmodule

>>> design/sliding_window_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median filter
// Keeps the last K samples in a sorted chain of cells and returns the lower
// median of each full window.
// ----------------------------------------------------------------------------
// A request is inserted into the cell chain at the edge that accepts it.
// While the window fills, a new request is taken every cycle.
// Once full, a request goes through insert, median select with oldest-entry
// search, then removal shift before the next is taken; output stalls hold select.
// The median is on the output from the edge that ends the select cycle.
// Reset is synchronous and active low; it empties the window and sets K to 1.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]           i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_median
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW = $clog2(MAX_WINDOW + 1) > 0 ? $clog2(MAX_WINDOW + 1) : 1;
    localparam int CW = (KW > swm_pkg::CFG_W) ? KW : swm_pkg::CFG_W;

    swm_pkg::t_swm_state r_state, n_state;

    logic [swm_pkg::CFG_W-1:0]           r_window;
    logic [KW-1:0]                       r_fill, n_fill;
    logic [IW-1:0]                       r_del_pos;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_median;
    logic                                r_out_valid;

    logic [KW-1:0]        w_k;
    logic [KW-1:0]        w_km1;
    logic [IW-1:0]        w_oldest_age;
    logic [IW-1:0]        w_med_idx;
    logic [IW-1:0]        w_pos;
    logic                 w_accept;
    logic                 w_out_free;
    logic [KW-1:0]        w_fill_ins;
    swm_pkg::t_cell_ctrl  w_ctrl;

    logic signed [swm_pkg::SAMPLE_W-1:0] w_val   [MAX_WINDOW];
    logic [IW-1:0]                       w_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]               w_valid;
    logic [MAX_WINDOW-1:0]               w_take;
    logic [MAX_WINDOW-1:0]               w_match;

    always_comb begin
        if (r_window == '0) begin
            w_k = KW'(1);
        end else if (CW'(r_window) > CW'(MAX_WINDOW)) begin
            w_k = KW'(MAX_WINDOW);
        end else begin
            w_k = KW'(r_window);
        end
    end

    assign w_km1        = w_k - 1'b1;
    assign w_oldest_age = w_km1[IW-1:0];
    assign w_med_idx    = w_km1[IW-1:0] >> 1;
    assign w_accept     = i_in_valid & o_in_ready;
    assign w_out_free   = ~r_out_valid | i_out_ready;
    assign w_fill_ins   = (i_restart ? '0 : r_fill) + 1'b1;

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IW'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (w_accept && (w_fill_ins == w_k)) begin
                    n_state = swm_pkg::ST_FIND;
                end
            end
            swm_pkg::ST_FIND: begin
                if (w_out_free) begin
                    n_state = swm_pkg::ST_DEL;
                end
            end
            swm_pkg::ST_DEL: begin
                n_state = swm_pkg::ST_IDLE;
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        w_ctrl        = '0;
        w_ctrl.clear  = i_cfg_wr_en;
        w_ctrl.flush  = i_restart;
        o_in_ready    = 1'b0;
        n_fill        = r_fill;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                w_ctrl.insert = w_accept;
                if (w_accept) begin
                    n_fill = w_fill_ins;
                end
            end
            swm_pkg::ST_FIND: begin
                o_in_ready = 1'b0;
            end
            swm_pkg::ST_DEL: begin
                w_ctrl.remove = 1'b1;
                n_fill        = r_fill - 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_IDLE;
            r_window    <= swm_pkg::CFG_W'(1);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if ((r_state == swm_pkg::ST_FIND) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == swm_pkg::ST_FIND) && w_out_free) begin
            r_median  <= w_val[w_med_idx];
            r_del_pos <= w_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic signed [swm_pkg::SAMPLE_W-1:0] w_lval, w_rval;
        logic [IW-1:0]                       w_lage, w_rage;
        logic                                w_lvalid, w_ltake, w_rvalid;

        if (i == 0) begin : g_first
            assign w_lval   = '0;
            assign w_lage   = '0;
            assign w_lvalid = 1'b0;
            assign w_ltake  = 1'b0;
        end else begin : g_mid
            assign w_lval   = w_val[i-1];
            assign w_lage   = w_age[i-1];
            assign w_lvalid = w_valid[i-1];
            assign w_ltake  = w_take[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign w_rval   = '0;
            assign w_rage   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rval   = w_val[i+1];
            assign w_rage   = w_age[i+1];
            assign w_rvalid = w_valid[i+1];
        end

        swm_cell #(
            .INDEX (i),
            .IW    (IW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_sample      (i_sample),
            .i_oldest_age  (w_oldest_age),
            .i_del_pos     (r_del_pos),
            .i_left_val    (w_lval),
            .i_left_age    (w_lage),
            .i_left_valid  (w_lvalid),
            .i_left_take   (w_ltake),
            .i_right_val   (w_rval),
            .i_right_age   (w_rage),
            .i_right_valid (w_rvalid),
            .o_val         (w_val[i]),
            .o_age         (w_age[i]),
            .o_valid       (w_valid[i]),
            .o_take        (w_take[i]),
            .o_match       (w_match[i])
        );
    end

    a_fill_le_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_k)
        else $error("Fill count exceeds the window size.");

    a_cells_match_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("Valid cells disagree with the fill count.");

    a_del_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swm_pkg::ST_DEL) |-> (r_fill == w_k))
        else $error("Removal started on a window that is not full.");

    a_find_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swm_pkg::ST_FIND && w_out_free) |=> r_out_valid)
        else $error("Median select did not load the output register.");

endmodule
